// ===== rtl/kvt_pkg.sv =====
// Package for the key-value table: capacity, index and count widths,
// status codes and sequencer state codes. It has no dependencies.
package kvt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;

    typedef logic [1:0] status_t;

    localparam status_t ST_HIT       = 2'd0;
    localparam status_t ST_INSERTED  = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

    localparam logic FUNC_SET = 1'b0;
    localparam logic FUNC_GET = 1'b1;

    typedef logic [1:0] state_t;

    localparam state_t S_IDLE  = 2'd0;
    localparam state_t S_SCAN  = 2'd1;
    localparam state_t S_VREAD = 2'd2;
    localparam state_t S_DONE  = 2'd3;

endpackage

// ===== rtl/kvt_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// It depends on nothing else.
module kvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/key_value_table_set_get.sv =====
// Key-value table with set and get: a linear scan over the stored keys.
// The scan stops at the first matching key or at the last stored entry; one key a cycle
// is read and compared. Throughput: one item at a time; the next item is taken the cycle
// after the result enters the output register. Reset clears the entry count, the
// sequencer state and the output valid flag; the key and value RAMs are not cleared,
// as only entries below the count are read.
module key_value_table_set_get (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic signed [kvt_pkg::KEY_W-1:0] key,
    input  logic [kvt_pkg::VAL_W-1:0]   value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [kvt_pkg::VAL_W-1:0]   read_value,
    output logic [1:0]                  status
);
    import kvt_pkg::*;

    // Sequencer state and counters.
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // Captured item.
    logic               func_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   value_reg;

    // Result being built, and the output register.
    logic [VAL_W-1:0]   res_value_reg, res_value_next;
    status_t            res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]   out_value_reg;
    status_t            out_status_reg;

    // RAM ports.
    logic               key_we, val_we;
    logic [IDX_W-1:0]   key_raddr, val_waddr, app_idx;
    logic [KEY_W-1:0]   key_rdata;
    logic [VAL_W-1:0]   val_rdata;

    logic               accept, out_free, match, last;
    logic [CNT_W-1:0]   idx_inc;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // The key read for entry idx_reg returns in the cycle the scan compares it.
    assign idx_inc  = CNT_W'(idx_reg) + CNT_W'(1);
    assign match    = (key_rdata == key_reg);
    assign last     = (idx_inc >= count_reg);
    assign app_idx  = IDX_W'(count_reg);

    // Key RAM: address zero is read on acceptance, then the next entry each scan cycle.
    assign key_raddr = (state_reg == S_SCAN) ? IDX_W'(idx_inc) : '0;

    kvt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (app_idx),
        .wdata (key_reg),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // Value RAM: a get that hits reads the matching slot, which is idx_reg.
    kvt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (value_reg),
        .raddr (idx_reg),
        .rdata (val_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        key_we          = 1'b0;
        val_we          = 1'b0;
        val_waddr       = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next       = '0;
                    res_value_next = '0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // An empty table is a miss without any compare.
                if ((count_reg != '0) && match)
                begin
                    res_status_next = ST_HIT;
                    if (func_reg == FUNC_GET)
                    begin
                        state_next = S_VREAD;
                    end
                    else
                    begin
                        val_we     = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else if ((count_reg != '0) && !last)
                begin
                    idx_next = IDX_W'(idx_inc);
                end
                else
                begin
                    state_next = S_DONE;
                    if (func_reg == FUNC_GET)
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                    else if (count_reg < CNT_W'(CAPACITY))
                    begin
                        key_we          = 1'b1;
                        val_we          = 1'b1;
                        val_waddr       = app_idx;
                        count_next      = count_reg + CNT_W'(1);
                        res_status_next = ST_INSERTED;
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                    end
                end
            end
            S_VREAD:
            begin
                res_value_next = val_rdata;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (accept)
        begin
            func_reg  <= func;
            key_reg   <= KEY_W'(unsigned'(key));
            value_reg <= value;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign status     = out_status_reg;

endmodule

// ===== tb/sv/kvt_checker.sv =====
`timescale 1ns / 100ps
// Checker for the key-value table: it watches both channels, keeps a table of its
// own, predicts each request's answer and compares it with the block's result.
// Depends on kvt_pkg for the capacity, the widths, the request codes and the status codes.
module kvt_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        func,
    input  logic [kvt_pkg::KEY_W-1:0]   key,
    input  logic [kvt_pkg::VAL_W-1:0]   value,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [kvt_pkg::VAL_W-1:0]   read_value,
    input  logic [1:0]                  status,
    output int unsigned                 mismatch_count,
    output int unsigned                 answers_owed
);
    import kvt_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        status_t          status;
    } kv_answer_t;

    logic [KEY_W-1:0] table_keys   [CAPACITY];
    logic [VAL_W-1:0] table_values [CAPACITY];
    int unsigned      table_count = 0;
    kv_answer_t       answers_due [$];

    // Applies one request to the shadow table and returns the answer it should give.
    function automatic kv_answer_t serve_request(logic req_func, logic [KEY_W-1:0] req_key,
                                                 logic [VAL_W-1:0] req_value);
        kv_answer_t ans;
        int         slot;
        ans.read_value = '0;
        slot = -1;
        for (int i = 0; i < table_count; i++)
            if (slot < 0 && table_keys[i] == req_key)
                slot = i;
        if (req_func == FUNC_SET)
        begin
            if (slot >= 0)
            begin
                table_values[slot] = req_value;
                ans.status = ST_HIT;
            end
            else if (table_count < CAPACITY)
            begin
                table_keys[table_count]   = req_key;
                table_values[table_count] = req_value;
                table_count++;
                ans.status = ST_INSERTED;
            end
            else
                ans.status = ST_FULL;
        end
        else
        begin
            if (slot >= 0)
            begin
                ans.read_value = table_values[slot];
                ans.status     = ST_HIT;
            end
            else
                ans.status = ST_NOT_FOUND;
        end
        return ans;
    endfunction

    always @(posedge clk)
    begin
        kv_answer_t  due;
        int unsigned errs;
        errs = 0;
        if (!rst_n)
        begin
            table_count = 0;
            answers_due.delete();
        end
        else
        begin
            // The result is checked before the request of the same edge is queued,
            // so a result can never be matched against its own request.
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    $display("%0t: result with nothing outstanding: read_value %h, status %0d",
                             $time, read_value, status);
                    errs++;
                end
                else
                begin
                    due = answers_due.pop_front();
                    if (read_value !== due.read_value)
                    begin
                        $display("%0t: read_value mismatch: expected %h, actual %h",
                                 $time, due.read_value, read_value);
                        errs++;
                    end
                    if (status !== due.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, due.status, status);
                        errs++;
                    end
                end
            end
            if (in_valid && !in_stall)
                answers_due.insert(answers_due.size(), serve_request(func, key, value));
        end
        mismatch_count <= (!rst_n) ? 0 : mismatch_count + errs;
        answers_owed   <= answers_due.size();
    end

endmodule

// ===== tb/sv/tb_key_value_table_set_get.sv =====
`timescale 1ns / 100ps
// Top of the key-value table testbench: clock, reset, request stimulus, result stall
// and the verdict. Depends on kvt_pkg, on key_value_table_set_get and on kvt_checker.
module tb_key_value_table_set_get;
    import kvt_pkg::*;

    // Stall behaviours of the result side; each one holds for a random stretch.
    typedef enum int unsigned {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_TOGGLE
    } rx_mode_e;

    localparam int RANDOM_ITEMS = 800;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic             func      = FUNC_SET;
    logic [KEY_W-1:0] key       = '0;
    logic [VAL_W-1:0] value     = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [VAL_W-1:0] read_value;
    logic [1:0]       status;

    int unsigned      mismatch_count;
    int unsigned      answers_owed;

    rx_mode_e         rx_mode      = RX_FREE;
    int unsigned      rx_mode_left = 0;

    // Every key that has been offered in a set request; drawing from this pool
    // is what makes gets find something and sets update rather than append.
    logic [KEY_W-1:0] keys_offered [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    key_value_table_set_get dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .key        (key),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .status     (status)
    );

    kvt_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .key            (key),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_value     (read_value),
        .status         (status),
        .mismatch_count (mismatch_count),
        .answers_owed   (answers_owed)
    );

    // The result side picks a behaviour for a random stretch of cycles: no stall at
    // all, an occasional stall, mostly stalled, or stalled on every other cycle.
    // Each stretch opens with one free cycle.
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      <= rx_mode_e'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(10, 80);
            out_stall    <= 1'b0;
        end
        else
        begin
            rx_mode_left <= rx_mode_left - 1;
            case (rx_mode)
                RX_FREE:  out_stall <= 1'b0;
                RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:  out_stall <= ~out_stall;
            endcase
        end
    end

    // Presents one request and returns at the edge at which it is taken. It must be
    // called at a rising edge. Valid is left high, so a request that follows at
    // once keeps the channel busy with no gap.
    task automatic send_item(logic req_func, logic [KEY_W-1:0] req_key,
                             logic [VAL_W-1:0] req_value);
        in_valid <= 1'b1;
        func     <= req_func;
        key      <= req_key;
        value    <= req_value;
        if (req_func == FUNC_SET)
            keys_offered.insert(keys_offered.size(), req_key);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drops valid for a number of cycles; zero leaves the channel untouched.
    task automatic idle_for(int unsigned cycles);
        if (cycles != 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Holds the request side quiet until every request has had its answer.
    // The first edge lets the count of outstanding answers catch up with the last
    // request taken.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (answers_owed != 0)
            @(posedge clk);
    endtask

    // Mostly keys that have been stored or refused before, some extreme patterns,
    // and the rest fresh random keys, which miss or hit the full table.
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60 && keys_offered.size() != 0)
            return keys_offered[$urandom_range(0, keys_offered.size() - 1)];
        else if (roll < 75)
            case ($urandom_range(0, 4))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        else
            return $urandom;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int unsigned sent;
        int unsigned burst;
        logic        paused;
        sent   = 0;
        paused = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening. A get on the empty table must miss; then the extreme
        // keys go in with extreme values, including a stored value of zero that a
        // get has to tell apart from a miss.
        send_item(FUNC_GET, 32'h0000_0000, 32'hDEAD_BEEF);
        send_item(FUNC_SET, 32'h8000_0000, 32'h0000_0000);
        send_item(FUNC_SET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(FUNC_SET, 32'h0000_0000, 32'hA5A5_A5A5);
        idle_for(3);
        send_item(FUNC_SET, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        send_item(FUNC_GET, 32'h8000_0000, 32'h1234_5678);
        send_item(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(FUNC_GET, 32'h0000_0001, 32'hFFFF_FFFF);
        // A set of a key already held overwrites its value in place.
        send_item(FUNC_SET, 32'h7FFF_FFFF, 32'h0000_0001);
        send_item(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);

        // Fill the remaining twelve entries so that the table is full. A random key
        // might repeat an earlier one, which the checker follows all the same.
        for (int i = 0; i < 12; i++)
            send_item(FUNC_SET,
                      {i[0], 31'($urandom_range(0, 32'h7FFF_FFFF))} ^ 32'h0F0F_0000,
                      pick_value());

        // On the full table a new key is refused, a held key is still updated, and
        // the refused key is not there afterwards.
        send_item(FUNC_SET, 32'h1234_5678, 32'hCAFE_F00D);
        send_item(FUNC_SET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(FUNC_GET, 32'h1234_5678, 32'h0000_0000);
        wait_for_drain();

        // Random part: bursts of random length with random gaps between them; about
        // a quarter of the gaps are empty, so bursts also run back to back.
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++)
            begin
                send_item($urandom_range(0, 1) ? FUNC_GET : FUNC_SET, pick_key(),
                          pick_value());
                sent++;
            end
            if (!paused && sent >= RANDOM_ITEMS / 2)
            begin
                // Halfway through, the sender holds back until everything is answered.
                paused = 1'b1;
                wait_for_drain();
            end
            else if ($urandom_range(0, 3) != 0)
                idle_for($urandom_range(1, 12));
        end

        // Let the last answers out, then allow for a full scan of extra cycles in
        // which a stray result would still be caught.
        wait_for_drain();
        repeat (CAPACITY + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_key_value_table_set_get: PASS");
        else
            $display("tb_key_value_table_set_get: FAIL");
        $finish;
    end

    // Guard against a hung handshake; a correct run needs well under a tenth of this.
    initial
    begin
        #5_000_000;
        $display("tb_key_value_table_set_get: FAIL");
        $finish;
    end

endmodule
